// ===== hdl/linear_key_value_table_defines.svh =====
// Assertion shorthands; clk and arst_n must be visible at the point of use.
`ifndef LINEAR_KEY_VALUE_TABLE_DEFINES_SVH
`define LINEAR_KEY_VALUE_TABLE_DEFINES_SVH

// Same-cycle implication.
`define LKVT_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lkvt assertion failed");

// Next-cycle implication.
`define LKVT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lkvt assertion failed");

`endif

// ===== hdl/lkvt_pkg.sv =====
package lkvt_pkg;

	// operation codes
	localparam logic [2:0] FN_LOOKUP = 3'd0;
	localparam logic [2:0] FN_APPEND = 3'd1;
	localparam logic [2:0] FN_UPDATE = 3'd2;
	localparam logic [2:0] FN_REMOVE = 3'd3;
	localparam logic [2:0] FN_READ   = 3'd4;
	localparam logic [2:0] FN_CLEAR  = 3'd5;

	// result status codes
	localparam logic [1:0] STAT_DONE = 2'd0;
	localparam logic [1:0] STAT_MISS = 2'd1;
	localparam logic [1:0] STAT_FULL = 2'd2;

	localparam logic [4:0] CAP_RESET = 5'd16;

	typedef struct packed {
		logic [2:0]  func;
		logic [31:0] key;
		logic [31:0] value;
		logic [3:0]  index;
	} in_word_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [3:0]  index_out;
		logic [31:0] key_out;
		logic [31:0] value_out;
		logic [4:0]  count;
	} out_word_t;

	// per-cell write controls
	typedef struct packed {
		logic shift;
		logic load_key;
		logic load_value;
	} cell_ctrl_t;

	// table-wide write commands, already qualified
	typedef struct packed {
		logic append;
		logic update;
		logic remove;
	} chain_cmd_t;

endpackage

// ===== hdl/lkvt_cell.sv =====
module lkvt_cell #(
	parameter int KEY_WIDTH   = 32,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                    clk,
	input  logic [KEY_WIDTH-1:0]    cmp_key,
	input  logic                    by_index,
	input  logic                    at_index,
	input  logic                    live,
	input  lkvt_pkg::cell_ctrl_t    ctrl,
	input  logic [VALUE_WIDTH-1:0]  new_value,
	input  logic [KEY_WIDTH-1:0]    next_key,
	input  logic [VALUE_WIDTH-1:0]  next_value,
	output logic [KEY_WIDTH-1:0]    key,
	output logic [VALUE_WIDTH-1:0]  value,
	output logic                    match
);

	logic [KEY_WIDTH-1:0]   key_q;
	logic [VALUE_WIDTH-1:0] value_q;
	logic                   match_q;

	always_ff @(posedge clk) begin
		match_q <= live & (by_index ? at_index : (key_q == cmp_key));
		if (ctrl.shift) begin
			// take the upper neighbor's entry
			key_q   <= next_key;
			value_q <= next_value;
		end else begin
			if (ctrl.load_key) begin
				key_q <= cmp_key;
			end
			if (ctrl.load_value) begin
				value_q <= new_value;
			end
		end
	end

	assign key   = key_q;
	assign value = value_q;
	assign match = match_q;

endmodule

// ===== hdl/lkvt_chain.sv =====
`include "linear_key_value_table_defines.svh"

module lkvt_chain #(
	parameter int DEPTH       = 16,
	parameter int KEY_WIDTH   = 32,
	parameter int VALUE_WIDTH = 32,
	parameter int IDX_W       = 4,
	parameter int CNT_W       = 5
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  lkvt_pkg::chain_cmd_t    cmd,
	input  logic [CNT_W-1:0]        count,
	input  logic                    by_index,
	input  logic [3:0]              index,
	input  logic [KEY_WIDTH-1:0]    cmp_key,
	input  logic [VALUE_WIDTH-1:0]  new_value,
	output logic                    hit,
	output logic [IDX_W-1:0]        pos,
	output logic [KEY_WIDTH-1:0]    key_sel,
	output logic [VALUE_WIDTH-1:0]  value_sel
);

	localparam int CMP_W = (IDX_W > 4) ? IDX_W : 4;

	logic [KEY_WIDTH-1:0]   key_a   [DEPTH];
	logic [VALUE_WIDTH-1:0] value_a [DEPTH];
	logic [DEPTH-1:0]       match_vec;
	logic [DEPTH-1:0]       first_vec;
	logic [DEPTH-1:0]       shift_vec;

	// lowest match, and every cell from it upward
	assign first_vec = match_vec & (~match_vec + 1'b1);
	assign shift_vec = ~first_vec + 1'b1;
	assign hit       = |match_vec;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		lkvt_pkg::cell_ctrl_t   ctrl;
		logic                   at_count;
		logic                   live;
		logic                   at_index;
		logic [KEY_WIDTH-1:0]   next_key;
		logic [VALUE_WIDTH-1:0] next_value;

		assign at_count = (CNT_W'(i) == count);
		assign live     = (CNT_W'(i) < count);
		assign at_index = (CMP_W'(i) == CMP_W'(index));

		assign ctrl.shift      = cmd.remove & shift_vec[i];
		assign ctrl.load_key   = cmd.append & at_count;
		assign ctrl.load_value = (cmd.append & at_count) | (cmd.update & first_vec[i]);

		if (i + 1 < DEPTH) begin : g_mid
			assign next_key   = key_a[i+1];
			assign next_value = value_a[i+1];
		end else begin : g_last
			// top cell holds; it falls out of range on remove
			assign next_key   = key_a[i];
			assign next_value = value_a[i];
		end

		lkvt_cell #(
			.KEY_WIDTH  (KEY_WIDTH),
			.VALUE_WIDTH(VALUE_WIDTH)
		) u_cell (
			.clk       (clk),
			.cmp_key   (cmp_key),
			.by_index  (by_index),
			.at_index  (at_index),
			.live      (live),
			.ctrl      (ctrl),
			.new_value (new_value),
			.next_key  (next_key),
			.next_value(next_value),
			.key       (key_a[i]),
			.value     (value_a[i]),
			.match     (match_vec[i])
		);
	end

	always_comb begin
		pos       = '0;
		key_sel   = '0;
		value_sel = '0;
		for (int i = 0; i < DEPTH; i++) begin
			pos       = pos | ({IDX_W{first_vec[i]}} & IDX_W'(i));
			key_sel   = key_sel | ({KEY_WIDTH{first_vec[i]}} & key_a[i]);
			value_sel = value_sel | ({VALUE_WIDTH{first_vec[i]}} & value_a[i]);
		end
	end

	`LKVT_ASSERT_IMPL(a_single_first, hit, $onehot(first_vec))
	`LKVT_ASSERT_IMPL(a_no_hit_no_shift, !hit, shift_vec == '0)

endmodule

// ===== hdl/linear_key_value_table.sv =====
// Flow: a word is taken in the accept cycle, then a compare cycle in the cell chain
// registers each cell's match, then a commit cycle picks the first match, writes the
// cells and registers the result. A new word is taken only once the previous one has
// committed. A word may be accepted while the previous result still waits on the
// output; its commit cycle then holds until that result is taken.
// Reset: count cleared, capacity set to 16, no result pending; table contents unreadable.
`include "linear_key_value_table_defines.svh"

module linear_key_value_table #(
	parameter int DEPTH       = 16,
	parameter int KEY_WIDTH   = 32,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [4:0]           cfg_wr_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  lkvt_pkg::in_word_t   in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output lkvt_pkg::out_word_t  out_data
);

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CAP_W = (CNT_W > 5) ? CNT_W : 5;

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_MATCH  = 3'b010,
		S_COMMIT = 3'b100
	} state_t;

	state_t               state_q;
	lkvt_pkg::in_word_t   req_q;
	logic [4:0]           capacity_q;
	logic [CNT_W-1:0]     count_q;
	lkvt_pkg::out_word_t  out_q;
	logic                 out_valid_q;

	logic                   apply;
	logic                   commit_stall;
	logic                   full;
	logic [CAP_W-1:0]       cap_eff;
	logic [CNT_W-1:0]       count_nx;
	lkvt_pkg::out_word_t    res;
	lkvt_pkg::chain_cmd_t   cmd;
	logic                   hit;
	logic [IDX_W-1:0]       pos;
	logic [KEY_WIDTH-1:0]   key_sel;
	logic [VALUE_WIDTH-1:0] value_sel;
	logic [VALUE_WIDTH-1:0] req_value;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// commit only when the output register is free or draining
	assign apply        = (state_q == S_COMMIT) && (!out_valid_q || out_ready);
	assign commit_stall = (state_q == S_COMMIT) && out_valid_q && !out_ready;
	assign req_value    = VALUE_WIDTH'(req_q.value);

	assign cap_eff = (CAP_W'(capacity_q) > CAP_W'(DEPTH)) ? CAP_W'(DEPTH) : CAP_W'(capacity_q);
	assign full    = (CAP_W'(count_q) >= cap_eff);

	assign cmd.append = apply && (req_q.func == lkvt_pkg::FN_APPEND) && !full;
	assign cmd.update = apply && (req_q.func == lkvt_pkg::FN_UPDATE);
	assign cmd.remove = apply && (req_q.func == lkvt_pkg::FN_REMOVE);

	lkvt_chain #(
		.DEPTH      (DEPTH),
		.KEY_WIDTH  (KEY_WIDTH),
		.VALUE_WIDTH(VALUE_WIDTH),
		.IDX_W      (IDX_W),
		.CNT_W      (CNT_W)
	) u_chain (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.count    (count_q),
		.by_index (req_q.func == lkvt_pkg::FN_READ),
		.index    (req_q.index),
		.cmp_key  (KEY_WIDTH'(req_q.key)),
		.new_value(req_value),
		.hit      (hit),
		.pos      (pos),
		.key_sel  (key_sel),
		.value_sel(value_sel)
	);

	always_comb begin
		res      = '0;
		count_nx = count_q;
		unique case (req_q.func)
			lkvt_pkg::FN_LOOKUP: begin
				if (hit) begin
					res.index_out = 4'(pos);
					res.value_out = 32'(value_sel);
				end else begin
					res.status = lkvt_pkg::STAT_MISS;
				end
			end
			lkvt_pkg::FN_APPEND: begin
				if (full) begin
					res.status = lkvt_pkg::STAT_FULL;
				end else begin
					count_nx = count_q + 1'b1;
				end
			end
			lkvt_pkg::FN_UPDATE: begin
				if (hit) begin
					res.value_out = 32'(req_value);
				end else begin
					res.status = lkvt_pkg::STAT_MISS;
				end
			end
			lkvt_pkg::FN_REMOVE: begin
				if (hit) begin
					res.value_out = 32'(value_sel);
					count_nx      = count_q - 1'b1;
				end else begin
					res.status = lkvt_pkg::STAT_MISS;
				end
			end
			lkvt_pkg::FN_READ: begin
				if (hit) begin
					res.key_out   = 32'(key_sel);
					res.value_out = 32'(value_sel);
				end else begin
					res.status = lkvt_pkg::STAT_MISS;
				end
			end
			lkvt_pkg::FN_CLEAR: begin
				count_nx = '0;
			end
			default: begin
			end
		endcase
		res.count = 5'(count_nx);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			capacity_q  <= lkvt_pkg::CAP_RESET;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				capacity_q <= cfg_wr_data;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_MATCH;
					end
				end
				S_MATCH: begin
					state_q <= S_COMMIT;
				end
				S_COMMIT: begin
					if (apply) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (apply) begin
				count_q     <= count_nx;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_q <= in_data;
		end
		if (apply) begin
			out_q <= res;
		end
	end

	`LKVT_ASSERT_NEXT(a_accept_to_match, in_valid && in_ready, state_q == S_MATCH)
	`LKVT_ASSERT_IMPL(a_count_step, count_q > $past(count_q), count_q == $past(count_q) + 1'b1)
	`LKVT_ASSERT_IMPL(a_result_from_commit, $rose(out_valid_q), $past(state_q) == S_COMMIT)
	`LKVT_ASSERT_NEXT(a_stall_holds, commit_stall, (state_q == S_COMMIT) && $stable(count_q))

endmodule

// ===== tb/linear_key_value_table_tb.sv =====
`timescale 1ns / 1ps

module linear_key_value_table_tb;
	import lkvt_pkg::*;

	localparam int TABLE_DEPTH = 16;
	// codes the block does not decode
	localparam logic [2:0] FN_SPARE6 = 3'd6;
	localparam logic [2:0] FN_SPARE7 = 3'd7;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_wr_en = 1'b0;
	logic [4:0] cfg_wr_data = '0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	in_word_t   in_data = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	out_word_t  out_data;

	linear_key_value_table uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

	// shadow copy of the table
	logic [31:0] tbl_keys   [TABLE_DEPTH];
	logic [31:0] tbl_values [TABLE_DEPTH];
	int          tbl_count = 0;
	int          tbl_capacity = CAP_RESET;

	out_word_t expected_results [$];
	int        mismatches = 0;
	int        send_idle_pct = 0;
	int        recv_stall_pct = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Mismatches found");
		$finish;
	end

	function automatic in_word_t make_word(input logic [2:0] func, input logic [31:0] key,
			input logic [31:0] value, input logic [3:0] index);
		in_word_t w;
		w.func = func;
		w.key = key;
		w.value = value;
		w.index = index;
		return w;
	endfunction

	// Apply one word to the shadow table and return the result it should give.
	function automatic out_word_t predict_table_result(input in_word_t w);
		out_word_t r;
		int hit;
		int lim;
		r = '0;
		r.status = STAT_DONE;
		lim = (tbl_capacity > TABLE_DEPTH) ? TABLE_DEPTH : tbl_capacity;
		hit = -1;
		for (int i = tbl_count - 1; i >= 0; i--) begin
			if (tbl_keys[i] == w.key) hit = i;
		end
		case (w.func)
			FN_LOOKUP: begin
				if (hit < 0) begin
					r.status = STAT_MISS;
				end else begin
					r.index_out = 4'(hit);
					r.value_out = tbl_values[hit];
				end
			end
			FN_APPEND: begin
				if (tbl_count >= lim) begin
					r.status = STAT_FULL;
				end else begin
					tbl_keys[tbl_count] = w.key;
					tbl_values[tbl_count] = w.value;
					tbl_count++;
				end
			end
			FN_UPDATE: begin
				if (hit < 0) begin
					r.status = STAT_MISS;
				end else begin
					tbl_values[hit] = w.value;
					r.value_out = w.value;
				end
			end
			FN_REMOVE: begin
				if (hit < 0) begin
					r.status = STAT_MISS;
				end else begin
					r.value_out = tbl_values[hit];
					for (int i = hit; i + 1 < tbl_count; i++) begin
						tbl_keys[i] = tbl_keys[i + 1];
						tbl_values[i] = tbl_values[i + 1];
					end
					tbl_count--;
				end
			end
			FN_READ: begin
				if (int'(w.index) >= tbl_count) begin
					r.status = STAT_MISS;
				end else begin
					r.key_out = tbl_keys[w.index];
					r.value_out = tbl_values[w.index];
				end
			end
			FN_CLEAR: begin
				tbl_count = 0;
			end
			default: begin
			end
		endcase
		r.count = 5'(tbl_count);
		return r;
	endfunction

	task automatic send_word(input in_word_t w);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		do @(posedge clk); while (!in_ready);
		expected_results.push_back(predict_table_result(w));
	endtask

	// Drop valid and hold until every result is back.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [4:0] cap);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= cap;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		tbl_capacity = cap;
	endtask

	always @(posedge clk) begin : result_check
		out_word_t exp;
		if (out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word: status %0d index %0d key %h value %h count %0d",
						out_data.status, out_data.index_out, out_data.key_out,
						out_data.value_out, out_data.count);
			end else begin
				exp = expected_results.pop_front();
				if (out_data.status !== exp.status || out_data.index_out !== exp.index_out ||
						out_data.key_out !== exp.key_out || out_data.value_out !== exp.value_out ||
						out_data.count !== exp.count) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"result mismatch: expected status %0d index %0d key %h value %h",
							" count %0d, got status %0d index %0d key %h value %h count %0d"},
							exp.status, exp.index_out, exp.key_out, exp.value_out, exp.count,
							out_data.status, out_data.index_out, out_data.key_out,
							out_data.value_out, out_data.count);
				end
			end
		end
		out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	task automatic test_empty_table();
		send_word(make_word(FN_LOOKUP, 32'h0, 32'h0, 4'h0));
		send_word(make_word(FN_UPDATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF));
		send_word(make_word(FN_REMOVE, 32'h0, 32'h0, 4'h0));
		send_word(make_word(FN_READ, 32'h0, 32'h0, 4'h0));
		send_word(make_word(FN_SPARE6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF));
	endtask

	task automatic test_insert_order();
		send_word(make_word(FN_APPEND, 32'h0, 32'h0, 4'h0));
		send_word(make_word(FN_APPEND, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF));
		// duplicate key: lookups must still hit the first copy
		send_word(make_word(FN_APPEND, 32'h0, 32'h1234_5678, 4'h0));
		send_word(make_word(FN_APPEND, 32'h8000_0001, 32'h7FFF_FFFE, 4'h0));
		send_word(make_word(FN_LOOKUP, 32'h0, 32'h0, 4'h0));
		send_word(make_word(FN_LOOKUP, 32'hFFFF_FFFF, 32'h0, 4'h0));
		send_word(make_word(FN_UPDATE, 32'h0, 32'hDEAD_BEEF, 4'h0));
		send_word(make_word(FN_READ, 32'h0, 32'h0, 4'h0));
		send_word(make_word(FN_READ, 32'h0, 32'h0, 4'h2));
		send_word(make_word(FN_READ, 32'h0, 32'h0, 4'h3));
		send_word(make_word(FN_READ, 32'h0, 32'h0, 4'h4));
		send_word(make_word(FN_READ, 32'h0, 32'h0, 4'hF));
		send_word(make_word(FN_REMOVE, 32'hFFFF_FFFF, 32'h0, 4'h0));
		send_word(make_word(FN_READ, 32'h0, 32'h0, 4'h1));
		send_word(make_word(FN_LOOKUP, 32'h8000_0001, 32'h0, 4'h0));
		send_word(make_word(FN_SPARE7, 32'h0, 32'h0, 4'h0));
		send_word(make_word(FN_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF));
		send_word(make_word(FN_LOOKUP, 32'h0, 32'h0, 4'h0));
	endtask

	task automatic test_capacity();
		wait_idle();
		write_capacity(5'd1);
		send_word(make_word(FN_APPEND, 32'h1, 32'h2, 4'h0));
		send_word(make_word(FN_APPEND, 32'h3, 32'h4, 4'h0));
		wait_idle();
		write_capacity(5'd0);
		send_word(make_word(FN_CLEAR, 32'h0, 32'h0, 4'h0));
		send_word(make_word(FN_APPEND, 32'h5, 32'h6, 4'h0));
		// capacity beyond the table size clips to the table size
		wait_idle();
		write_capacity(5'd31);
		repeat (TABLE_DEPTH + 1) send_word(make_word(FN_APPEND, $urandom, $urandom, 4'($urandom)));
		send_word(make_word(FN_READ, 32'h0, 32'h0, 4'hF));
		// lower the capacity under the count: entries stay, appends report full
		wait_idle();
		write_capacity(5'd4);
		send_word(make_word(FN_APPEND, 32'h7, 32'h8, 4'h0));
		send_word(make_word(FN_REMOVE, tbl_keys[3], 32'h0, 4'h0));
		send_word(make_word(FN_APPEND, 32'h9, 32'hA, 4'h0));
		wait_idle();
		write_capacity(CAP_RESET);
		send_word(make_word(FN_APPEND, 32'hB, 32'hC, 4'h0));
	endtask

	task automatic run_random_block(input int n);
		in_word_t w;
		int pick;
		int sel;
		int t;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(0, 99);
			w.func = pick < 30 ? FN_APPEND : pick < 50 ? FN_LOOKUP : pick < 62 ? FN_UPDATE :
				pick < 77 ? FN_REMOVE : pick < 92 ? FN_READ : pick < 95 ? FN_CLEAR :
				pick < 98 ? FN_SPARE6 : FN_SPARE7;
			// favor keys already stored so searches hit
			pick = $urandom_range(0, 99);
			if (pick < 60 && tbl_count > 0) begin
				w.key = tbl_keys[$urandom_range(0, tbl_count - 1)];
			end else if (pick < 85) begin
				sel = $urandom_range(0, 7);
				w.key = (sel == 0) ? 32'h0 : (sel == 1) ? 32'hFFFF_FFFF : {28'h5A5A5A5, 4'(sel)};
			end else begin
				w.key = $urandom;
			end
			w.value = $urandom;
			if ($urandom_range(0, 9) < 7) begin
				t = $urandom_range(0, tbl_count);
				if (t > TABLE_DEPTH - 1) t = TABLE_DEPTH - 1;
				w.index = 4'(t);
			end else begin
				w.index = 4'($urandom);
			end
			send_word(w);
		end
	endtask

	task automatic test_random_traffic();
		int pick;
		logic [4:0] cap;
		for (int ph = 0; ph < 4; ph++) begin
			wait_idle();
			case (ph)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 49;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 49;
				end
				default: begin
					send_idle_pct = 12;
					recv_stall_pct = 12;
				end
			endcase
			for (int b = 0; b < 4; b++) begin
				wait_idle();
				pick = $urandom_range(0, 9);
				if (pick == 0)
					cap = 5'd0;
				else if (pick == 1)
					cap = 5'($urandom_range(TABLE_DEPTH + 1, 31));
				else
					cap = 5'($urandom_range(1, TABLE_DEPTH));
				write_capacity(cap);
				run_random_block(50);
			end
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 12;
		recv_stall_pct = 12;
		test_empty_table();
		test_insert_order();
		test_capacity();
		test_random_traffic();
		wait_idle();
		repeat (10) @(posedge clk);
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/lkvt_pkg.sv
hdl/lkvt_cell.sv
hdl/lkvt_chain.sv
hdl/linear_key_value_table.sv
tb/linear_key_value_table_tb.sv
